// File: hw/rtl/identifier_interning_hash_table_top_assert.svh
// assertion macros shared by the checker
`ifndef IDENTIFIER_INTERNING_HASH_TABLE_TOP_ASSERT_SVH
`define IDENTIFIER_INTERNING_HASH_TABLE_TOP_ASSERT_SVH

`define IIHT_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

`define IIHT_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/iiht_pkg.sv
package iiht_pkg;

  localparam int BUCKETS = 256;
  localparam int MAX_LEN = 32;
  localparam int SLOT_W = $clog2(BUCKETS);
  localparam int LEN_W = $clog2(MAX_LEN + 2);
  localparam int POS_W = $clog2(MAX_LEN);
  localparam int CNT_W = SLOT_W + 1;

  localparam logic [63:0] FNV64_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV64_PRIME = 64'h00000100000001b3;
  localparam logic [63:0] FNV32_BASIS = 64'h00000000811c9dc5;
  localparam logic [31:0] FNV32_PRIME = 32'h01000193;
  localparam logic [63:0] DJB_BASIS = 64'd5381;

  localparam logic [1:0] SEL_FNV64 = 2'd0;
  localparam logic [1:0] SEL_FNV32 = 2'd1;

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  localparam logic CFG_HASH_SELECT = 1'b0;
  localparam logic CFG_ITEM_LIMIT = 1'b1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic is_last;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] slot;
    logic [63:0] hash_value;
  } out_beat_t;

  function automatic logic [63:0] hash_basis(input logic [1:0] sel);
    if (sel == SEL_FNV64) return FNV64_BASIS;
    if (sel == SEL_FNV32) return FNV32_BASIS;
    return DJB_BASIS;
  endfunction

endpackage

// File: hw/rtl/identifier_interning_hash_table_top.sv
// identifier interning table, fnv-1a / xor-djb2 hash with linear probing
// in channel: one beat per byte of an identifier, is_last on the final byte
// cfg channel: index 0 hash_select, 1 item_limit, taken only while idle
// out channel: one beat per identifier (status, slot, hash_value)
// a byte passes the accept state, then under 64-bit fnv a shared 32x32
// multiplier forms the three partial products of the low 64 bits in turn,
// then an add step; 32-bit fnv and djb use one multiply or shift-add step before it
// the final byte then probes unless the name is too long: each slot takes a
// length read and a check, plus a compare step per stored byte when the lengths
// match; an insert adds a copy step per byte, then the result is loaded
// reset: entry marks cleared at once by per-slot valid flops, count zero,
// hash_select 0, item_limit 192
// the result sits in an output register; while out_ready is low the block
// holds it and takes no new byte and no cfg beat until it is taken
module identifier_interning_hash_table_top
  import iiht_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_beat_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_beat_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [7:0] cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL = 4'd1;
  localparam logic [3:0] S_ADD = 4'd2;
  localparam logic [3:0] S_LEN = 4'd3;
  localparam logic [3:0] S_CHK = 4'd4;
  localparam logic [3:0] S_CMP = 4'd5;
  localparam logic [3:0] S_COPY = 4'd6;
  localparam logic [3:0] S_OUT = 4'd7;

  localparam logic [POS_W:0] POS_ONE = {{POS_W{1'b0}}, 1'b1};

  logic [3:0] state_r;
  logic [1:0] sel_r;
  logic [7:0] limit_r;
  logic [63:0] hash_r;
  logic [63:0] x_r;
  logic [63:0] acc_r;
  logic [1:0] pp_r;
  logic [1:0] bsel_r;
  logic [7:0] byte_r;
  logic last_r;
  logic [LEN_W-1:0] len_r;
  logic [SLOT_W-1:0] idx_r;
  logic [CNT_W-1:0] tries_r;
  logic [POS_W:0] pos_r;
  logic [CNT_W-1:0] count_r;
  logic [BUCKETS-1:0] used_r;
  out_beat_t out_r;
  logic out_valid_r;

  logic [7:0] name_mem [MAX_LEN];
  logic [LEN_W-1:0] slen_mem [BUCKETS];
  logic [7:0] text_mem [BUCKETS*MAX_LEN];
  logic [LEN_W-1:0] slen_q;
  logic [7:0] text_q, name_q;

  logic [31:0] ma, mb;
  logic [63:0] mp;
  logic [63:0] base;
  logic [63:0] h_add;
  logic fnv_b;
  logic [POS_W:0] pos_m1;
  logic [SLOT_W+POS_W-1:0] taddr;
  logic [SLOT_W+POS_W-1:0] waddr;
  logic ins_ok;

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign cfg_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  assign base = (len_r == '0) ? hash_basis(sel_r) : hash_r;
  assign fnv_b = (bsel_r == SEL_FNV64) || (bsel_r == SEL_FNV32);
  assign h_add = fnv_b ? acc_r : (acc_r ^ {56'd0, byte_r});
  assign pos_m1 = pos_r - 1'b1;
  assign taddr = {idx_r, pos_r[POS_W-1:0]};
  assign waddr = {idx_r, pos_m1[POS_W-1:0]};
  assign ins_ok = !used_r[idx_r] && (count_r < CNT_W'(limit_r));

  always_comb begin
    ma = pp_r[0] ? x_r[63:32] : x_r[31:0];
    mb = pp_r[1] ? FNV64_PRIME[63:32] : FNV64_PRIME[31:0];
    if (bsel_r == SEL_FNV32) mb = FNV32_PRIME;
    mp = 64'(ma) * 64'(mb);
  end

  always_ff @(posedge clk) begin
    slen_q <= slen_mem[idx_r];
    text_q <= text_mem[taddr];
    name_q <= name_mem[pos_r[POS_W-1:0]];
    if (state_r == S_COPY) begin
      text_mem[waddr] <= name_q;
    end
    if (state_r == S_CHK && ins_ok) begin
      slen_mem[idx_r] <= len_r;
    end
    if (in_valid && in_ready && len_r < LEN_W'(MAX_LEN)) begin
      name_mem[len_r[POS_W-1:0]] <= in_data.text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r <= 2'd0;
      limit_r <= 8'd192;
      hash_r <= FNV64_BASIS;
      len_r <= '0;
      count_r <= '0;
      used_r <= '0;
      out_valid_r <= 1'b0;
      pp_r <= '0;
      pos_r <= '0;
      tries_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_HASH_SELECT) sel_r <= cfg_data[1:0];
        else limit_r <= cfg_data;
      end
      if (state_r == S_OUT) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          state_r <= S_MUL;
          bsel_r <= sel_r;
          last_r <= in_data.is_last;
          byte_r <= in_data.text_byte;
          x_r <= (sel_r == SEL_FNV64 || sel_r == SEL_FNV32) ?
                 (base ^ {56'd0, in_data.text_byte}) : base;
          pp_r <= '0;
          len_r <= (len_r < LEN_W'(MAX_LEN)) ? len_r + 1'b1 : LEN_W'(MAX_LEN + 1);
        end
        S_MUL: begin
          if (bsel_r == SEL_FNV64) begin
            if (pp_r == 2'd0) acc_r <= mp;
            else acc_r <= acc_r + {mp[31:0], 32'd0};
            pp_r <= pp_r + 1'b1;
            if (pp_r == 2'd2) state_r <= S_ADD;
          end else if (bsel_r == SEL_FNV32) begin
            acc_r <= {32'd0, mp[31:0]};
            state_r <= S_ADD;
          end else begin
            acc_r <= {x_r[58:0], 5'd0} + x_r;
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          hash_r <= h_add;
          if (!last_r) begin
            state_r <= S_IDLE;
          end else begin
            out_r.hash_value <= h_add;
            out_r.status <= ST_TOO_LONG;
            out_r.slot <= 8'd0;
            idx_r <= h_add[SLOT_W-1:0];
            tries_r <= '0;
            state_r <= (len_r > LEN_W'(MAX_LEN)) ? S_OUT : S_LEN;
          end
        end
        S_LEN: begin
          pos_r <= '0;
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (!used_r[idx_r]) begin
            if (!ins_ok) begin
              out_r.status <= ST_FULL;
              out_r.slot <= 8'd0;
              state_r <= S_OUT;
            end else begin
              used_r[idx_r] <= 1'b1;
              count_r <= count_r + 1'b1;
              out_r.status <= ST_INSERTED;
              out_r.slot <= 8'(idx_r);
              pos_r <= POS_ONE;
              state_r <= S_COPY;
            end
          end else if (slen_q != len_r) begin
            idx_r <= idx_r + 1'b1;
            tries_r <= tries_r + 1'b1;
            out_r.status <= ST_FULL;
            out_r.slot <= 8'd0;
            state_r <= (tries_r == CNT_W'(BUCKETS - 1)) ? S_OUT : S_LEN;
          end else begin
            pos_r <= POS_ONE;
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (text_q != name_q) begin
            idx_r <= idx_r + 1'b1;
            tries_r <= tries_r + 1'b1;
            out_r.status <= ST_FULL;
            out_r.slot <= 8'd0;
            state_r <= (tries_r == CNT_W'(BUCKETS - 1)) ? S_OUT : S_LEN;
          end else if (LEN_W'(pos_r) == len_r) begin
            out_r.status <= ST_FOUND;
            out_r.slot <= 8'(idx_r);
            state_r <= S_OUT;
          end else begin
            pos_r <= pos_r + 1'b1;
          end
        end
        S_COPY: begin
          if (LEN_W'(pos_r) == len_r) state_r <= S_OUT;
          else pos_r <= pos_r + 1'b1;
        end
        S_OUT: begin
          len_r <= '0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/iiht_checker.sv
module iiht_checker
  import iiht_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_beat_t in_data,
  input logic out_valid,
  input logic out_ready,
  input out_beat_t out_data
);

`include "identifier_interning_hash_table_top_assert.svh"

  logic err_beat;
  assign err_beat = (out_data.status == ST_FULL) || (out_data.status == ST_TOO_LONG);

  `IIHT_ASSERT_IMPL(a_err_slot, out_valid && err_beat, out_data.slot == 8'd0)
  `IIHT_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `IIHT_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready)
  `IIHT_ASSERT_IMPL(a_no_overlap, out_valid, !in_ready)

endmodule

bind identifier_interning_hash_table_top iiht_checker u_iiht_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data)
);

// File: tb/sv/tb_identifier_interning_hash_table_top.sv
module tb_identifier_interning_hash_table_top;
  import iiht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 20;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_beat_t in_data;
  logic out_valid;
  logic out_ready;
  out_beat_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [7:0] cfg_data;

  identifier_interning_hash_table_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // model of the table
  logic [1:0] sel_q;
  logic [7:0] limit_q;
  logic [63:0] run_hash;
  logic [7:0] name_buf [MAX_LEN];
  int name_len;
  bit slot_used [BUCKETS];
  int slot_len [BUCKETS];
  logic [7:0] slot_text [BUCKETS][MAX_LEN];
  int entry_count;

  out_beat_t pending_results [$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 4;
  bit no_gaps = 0;
  bit hold_long = 0;

  logic [7:0] pool_txt [64][40];
  int pool_len [64];
  int pool_n = 0;

  function automatic logic [63:0] basis_of(input logic [1:0] s);
    case (s)
      SEL_FNV64: return FNV64_BASIS;
      SEL_FNV32: return FNV32_BASIS;
      default: return DJB_BASIS;
    endcase
  endfunction

  function automatic logic [63:0] mix_byte(input logic [63:0] h, input logic [7:0] b,
                                           input logic [1:0] s);
    logic [31:0] t;
    case (s)
      SEL_FNV64: return (h ^ {56'd0, b}) * FNV64_PRIME;
      SEL_FNV32: begin
        t = h[31:0] ^ {24'd0, b};
        t = t * FNV32_PRIME;
        return {32'd0, t};
      end
      default: return (h * 64'd33) ^ {56'd0, b};
    endcase
  endfunction

  task automatic hash_intern(input logic [7:0] b, input bit last, output bit has,
                             output out_beat_t r);
    int idx;
    int len;
    bit hit;
    bit have_free;
    bit same;
    has = 0;
    r = '0;
    hit = 0;
    have_free = 0;
    if (name_len == 0) run_hash = basis_of(sel_q);
    run_hash = mix_byte(run_hash, b, sel_q);
    if (name_len < MAX_LEN) begin
      name_buf[name_len] = b;
      name_len++;
    end else begin
      name_len = MAX_LEN + 1;
    end
    if (!last) return;
    has = 1;
    len = name_len;
    r.hash_value = run_hash;
    name_len = 0;
    run_hash = basis_of(sel_q);
    if (len > MAX_LEN) begin
      r.status = ST_TOO_LONG;
      return;
    end
    idx = int'(r.hash_value[7:0]);
    for (int i = 0; i < BUCKETS; i++) begin
      if (!slot_used[idx]) begin
        have_free = 1;
        break;
      end
      same = (slot_len[idx] == len);
      for (int k = 0; k < len && same; k++)
        if (slot_text[idx][k] != name_buf[k]) same = 0;
      if (same) begin
        hit = 1;
        break;
      end
      idx = (idx + 1) % BUCKETS;
    end
    if (hit) begin
      r.status = ST_FOUND;
      r.slot = idx[7:0];
    end else if (!have_free || entry_count >= int'(limit_q)) begin
      r.status = ST_FULL;
    end else begin
      slot_used[idx] = 1;
      slot_len[idx] = len;
      for (int k = 0; k < len; k++) slot_text[idx][k] = name_buf[k];
      entry_count++;
      r.status = ST_INSERTED;
      r.slot = idx[7:0];
    end
  endtask

  // byte beat; optional typed status and slot zero for the directed rows
  task automatic push_byte(input logic [7:0] b, input bit last, input bit pin = 0,
                           input logic [1:0] pin_st = ST_FOUND, input bit pin_zero = 0);
    bit has;
    out_beat_t r;
    in_valid = 1'b1;
    in_data.text_byte = b;
    in_data.is_last = last;
    do @(posedge clk); while (!in_ready);
    hash_intern(b, last, has, r);
    if (has) begin
      if (pin) begin
        if (r.status != pin_st || (pin_zero && r.slot != 8'd0)) begin
          $display("%0t model disagrees with table: expected status %0d, model %0d",
                   $time, pin_st, r.status);
          errors++;
        end
        r.status = pin_st;
        if (pin_zero) r.slot = 8'd0;
      end
      pending_results.push_back(r);
    end
    @(negedge clk);
    burst_left--;
    if (!no_gaps && burst_left <= 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_HASH_SELECT) sel_q = val[1:0];
    else limit_q = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_name;
    int len;
    int p;
    logic [7:0] txt [40];
    if (pool_n > 0 && $urandom_range(0, 9) < 4) begin
      p = $urandom_range(0, (pool_n < 64 ? pool_n : 64) - 1);
      len = pool_len[p];
      for (int k = 0; k < len; k++) txt[k] = pool_txt[p][k];
    end else begin
      p = $urandom_range(0, 99);
      len = (p < 85) ? $urandom_range(1, 6) : (p < 95) ? $urandom_range(7, 32)
                                                      : $urandom_range(33, 40);
      for (int k = 0; k < len; k++)
        txt[k] = $urandom_range(0, 1) ? 8'h61 + 8'($urandom_range(0, 3))
                                      : 8'($urandom_range(0, 255));
      p = pool_n % 64;
      pool_len[p] = len;
      for (int k = 0; k < len; k++) pool_txt[p][k] = txt[k];
      pool_n++;
    end
    for (int k = 0; k < len; k++) push_byte(txt[k], k == len - 1);
  endtask

  typedef struct {
    bit is_cfg;
    logic idx;
    logic [7:0] val;
    logic [7:0] b;
    bit last;
    int reps;
    bit pin;
    logic [1:0] st;
    bit zero;
  } step_row_t;

  step_row_t directed [] = '{
    '{0, 0, 0, 8'h61, 1, 1, 1, ST_INSERTED, 0},
    '{0, 0, 0, 8'h61, 1, 1, 1, ST_FOUND, 0},
    '{0, 0, 0, 8'h00, 1, 1, 1, ST_INSERTED, 0},
    '{0, 0, 0, 8'hff, 1, 1, 1, ST_INSERTED, 0},
    '{0, 0, 0, 8'h41, 0, 33, 0, ST_FOUND, 0},
    '{0, 0, 0, 8'h78, 1, 1, 1, ST_TOO_LONG, 1},
    '{0, 0, 0, 8'h5a, 0, 31, 0, ST_FOUND, 0},
    '{0, 0, 0, 8'ha5, 1, 1, 1, ST_INSERTED, 0},
    '{0, 0, 0, 8'h5a, 0, 31, 0, ST_FOUND, 0},
    '{0, 0, 0, 8'ha5, 1, 1, 1, ST_FOUND, 0},
    '{1, CFG_ITEM_LIMIT, 8'd0, 0, 0, 0, 0, ST_FOUND, 0},
    '{0, 0, 0, 8'h61, 1, 1, 1, ST_FOUND, 0},
    '{0, 0, 0, 8'h71, 1, 1, 1, ST_FULL, 1},
    '{1, CFG_ITEM_LIMIT, 8'd192, 0, 0, 0, 0, ST_FOUND, 0},
    '{1, CFG_HASH_SELECT, 8'd1, 0, 0, 0, 0, ST_FOUND, 0},
    '{0, 0, 0, 8'h71, 1, 1, 0, ST_FOUND, 0},
    '{1, CFG_HASH_SELECT, 8'd3, 0, 0, 0, 0, ST_FOUND, 0},
    '{0, 0, 0, 8'h72, 1, 1, 0, ST_FOUND, 0},
    '{0, 0, 0, 8'h6d, 0, 1, 0, ST_FOUND, 0},
    '{1, CFG_HASH_SELECT, 8'd0, 0, 0, 0, 0, ST_FOUND, 0},
    '{0, 0, 0, 8'h6e, 0, 1, 0, ST_FOUND, 0},
    '{1, CFG_HASH_SELECT, 8'd1, 0, 0, 0, 0, ST_FOUND, 0},
    '{0, 0, 0, 8'h6f, 1, 1, 0, ST_FOUND, 0}
  };

  logic [1:0] phase_sel [8] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd2, 2'd0};
  logic [7:0] phase_lim [8] = '{8'd255, 8'd1, 8'd192, 8'd255, 8'd0, 8'd8, 8'd255, 8'd200};

  // receiver stall pattern
  initial begin
    int mode;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_long = 0;
      end
      if (cycles % 64 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_ready = 1'b1;
        1: out_ready = $urandom_range(0, 1);
        default: out_ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    out_beat_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected beat: actual %p", $time, out_data);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_data.status != e.status) begin
          $display("%0t status: expected %0d actual %0d", $time, e.status, out_data.status);
          errors++;
        end
        if (out_data.slot != e.slot) begin
          $display("%0t slot: expected %0d actual %0d", $time, e.slot, out_data.slot);
          errors++;
        end
        if (out_data.hash_value != e.hash_value) begin
          $display("%0t hash_value: expected %h actual %h", $time, e.hash_value,
                   out_data.hash_value);
          errors++;
        end
      end
    end
  end

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_HASH_SELECT;
    cfg_data = 8'd0;
    rst_n = 1'b0;
    sel_q = SEL_FNV64;
    limit_q = 8'd192;
    run_hash = FNV64_BASIS;
    name_len = 0;
    entry_count = 0;
    for (int i = 0; i < BUCKETS; i++) slot_used[i] = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_reg(directed[i].idx, directed[i].val);
      else
        for (int k = 0; k < directed[i].reps; k++)
          push_byte(directed[i].b, directed[i].last && k == directed[i].reps - 1,
                    directed[i].pin, directed[i].st, directed[i].zero);
    end

    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 8) begin
        write_reg(CFG_HASH_SELECT, {6'd0, phase_sel[ph]});
        write_reg(CFG_ITEM_LIMIT, phase_lim[ph]);
      end else begin
        write_reg(CFG_HASH_SELECT, 8'($urandom_range(0, 3)));
        write_reg(CFG_ITEM_LIMIT, 8'($urandom_range(0, 255)));
      end
      no_gaps = (ph % 3 == 2);
      if (ph == 1) hold_long = 1;
      repeat (32) send_name();
      // leave a name open across the next register write, or up to the final byte
      if ($urandom_range(0, 1))
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 0);
    end
    push_byte(8'h7a, 1);

    drain();
    repeat (50) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/iiht_pkg.sv
hw/rtl/identifier_interning_hash_table_top.sv
hw/rtl/iiht_checker.sv
tb/sv/tb_identifier_interning_hash_table_top.sv
